[src/b64d_pkg.sv]
// Shared types and constants of the base64 chunk decoder.
`default_nettype none

package b64d_pkg;

  localparam int unsigned CharW = 8;
  localparam int unsigned CapW = 12;
  localparam int unsigned CountW = 10;
  localparam int unsigned CharCntW = 11;

  // Limits of one chunk.
  localparam logic [CharCntW-1:0] MaxChars = 11'd1024;
  localparam logic [CountW-1:0] MaxBytes = 10'd768;
  localparam logic [CharCntW-1:0] CharCntSat = 11'd2047;
  localparam logic [CapW-1:0] CapReset = 12'd768;

  localparam logic KindData = 1'b0;
  localparam logic KindStatus = 1'b1;

  typedef enum logic [2:0] {
    StOk = 3'd0,
    StEmpty = 3'd1,
    StTooLong = 3'd2,
    StInvalid = 3'd3,
    StOversized = 3'd4
  } status_e;

  typedef struct packed {
    logic [CharW-1:0] character;
    logic last;
    logic empty_chunk;
  } in_item_t;

  typedef struct packed {
    logic kind;
    logic [7:0] data_byte;
    status_e status;
    logic [CountW-1:0] byte_count;
    logic end_of_run;
  } out_item_t;

  // Per-chunk decoding state.
  typedef struct packed {
    logic [17:0] group;
    logic [1:0] pos;
    logic [CharCntW-1:0] char_count;
    logic bad;
    logic [1:0] pad;
  } run_state_t;

  // Everything one character produces: up to three bytes, left aligned,
  // and an optional status.
  typedef struct packed {
    logic [1:0] n_bytes;
    logic [23:0] bytes;
    logic has_status;
    status_e status;
    logic [CountW-1:0] byte_count;
  } bundle_t;

endpackage

`default_nettype wire

[src/b64d_decode.sv]
// Combinational decode of one character against the current run state.
`default_nettype none

module b64d_decode
  import b64d_pkg::*;
(
  input  in_item_t         item_i,
  input  run_state_t       run_i,
  input  logic [CapW-1:0]  out_capacity_i,
  output run_state_t       run_o,
  output bundle_t          bundle_o
);

  localparam logic [6:0] PadCode = 7'd64;
  localparam logic [6:0] BadCode = 7'd65;

  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if (c inside {[8'h41:8'h5A]}) begin
      d = c - 8'h41;
    end else if (c inside {[8'h61:8'h7A]}) begin
      d = c - 8'h61 + 8'd26;
    end else if (c inside {[8'h30:8'h39]}) begin
      d = c - 8'h30 + 8'd52;
    end else if (c == 8'h2B) begin
      d = 8'd62;
    end else if (c == 8'h2F) begin
      d = 8'd63;
    end else if (c == 8'h3D) begin
      d = {1'b0, PadCode};
    end else begin
      d = {1'b0, BadCode};
    end
    return d[6:0];
  endfunction

  logic [6:0]  sextet;
  logic        is_pad;
  logic        is_bad;
  logic [5:0]  val;
  logic        c2pad;
  logic [23:0] grp;
  logic [7:0]  b0, b1, b2;
  run_state_t  upd;
  logic [8:0]  quads;
  logic [CountW-1:0] dlen;
  status_e     fin_status;

  always_comb begin
    sextet = sextet_of(item_i.character);
    is_pad = (sextet == PadCode);
    is_bad = (sextet == BadCode);
    val = sextet[6] ? 6'd0 : sextet[5:0];
    c2pad = (run_i.pad != 2'd0);
    grp = {run_i.group, val};
    b0 = grp[23:16];
    b1 = grp[15:8];
    b2 = grp[7:0];

    upd.bad = run_i.bad | is_bad
            | ((run_i.pos == 2'd0) && (run_i.pad != 2'd0))
            | (is_pad && !run_i.pos[1])
            | ((run_i.pos == 2'd3) && c2pad && !is_pad);
    upd.group = (run_i.pos == 2'd3) ? 18'd0 : {run_i.group[11:0], val};
    upd.pos = run_i.pos + 2'd1;
    upd.char_count = (run_i.char_count < CharCntSat) ? run_i.char_count + 11'd1
                                                     : run_i.char_count;
    if (is_pad) begin
      upd.pad = (run_i.pad < 2'd2) ? run_i.pad + 2'd1 : 2'd2;
    end else begin
      upd.pad = 2'd0;
    end

    // Decoded length, meaningful once the count is a multiple of four and
    // within the character limit.
    quads = upd.char_count[10:2];
    dlen = {quads, 1'b0} + {1'b0, quads} - {8'd0, upd.pad};
    if (upd.char_count > MaxChars) begin
      fin_status = StTooLong;
    end else if (upd.char_count[1:0] != 2'd0) begin
      fin_status = StInvalid;
    end else if ((dlen > MaxBytes) || ({2'b00, dlen} > out_capacity_i)) begin
      fin_status = StOversized;
    end else if (upd.bad) begin
      fin_status = StInvalid;
    end else begin
      fin_status = StOk;
    end

    bundle_o = '0;
    run_o = upd;
    if (item_i.empty_chunk) begin
      bundle_o.has_status = 1'b1;
      bundle_o.status = StEmpty;
      run_o = '0;
    end else begin
      if (run_i.pos == 2'd3) begin
        // A pad in third place drops the middle byte, one in fourth place the last.
        bundle_o.bytes = {b0, c2pad ? b2 : b1, b2};
        bundle_o.n_bytes = 2'd1 + {1'b0, !c2pad} + {1'b0, !is_pad};
      end
      if (item_i.last) begin
        bundle_o.has_status = 1'b1;
        bundle_o.status = fin_status;
        bundle_o.byte_count = (fin_status == StOk) ? dlen : '0;
        run_o = '0;
      end
    end
  end

endmodule

`default_nettype wire

[src/b64d_serializer.sv]
// Result buffer that sends one character's bytes and status one beat at a time.
`default_nettype none

module b64d_serializer
  import b64d_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  bundle_t   bundle_i,
  output logic      can_load_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  logic [1:0]        byte_cnt_q, byte_cnt_d;
  logic              stat_pend_q, stat_pend_d;
  logic [23:0]       bytes_q, bytes_d;
  status_e           status_q, status_d;
  logic [CountW-1:0] count_q, count_d;
  logic              pop;
  logic              one_left;

  assign out_valid_o = (byte_cnt_q != 2'd0) || stat_pend_q;
  assign pop = out_valid_o && out_ready_i;
  assign one_left = ((byte_cnt_q == 2'd0) && stat_pend_q)
                 || ((byte_cnt_q == 2'd1) && !stat_pend_q);
  assign can_load_o = !out_valid_o || (out_ready_i && one_left);

  always_comb begin
    out_data_o = '0;
    if (byte_cnt_q != 2'd0) begin
      out_data_o.kind = KindData;
      out_data_o.data_byte = bytes_q[23:16];
    end else begin
      out_data_o.kind = KindStatus;
      out_data_o.status = status_q;
      out_data_o.byte_count = count_q;
      out_data_o.end_of_run = 1'b1;
    end
  end

  always_comb begin
    byte_cnt_d = byte_cnt_q;
    stat_pend_d = stat_pend_q;
    bytes_d = bytes_q;
    status_d = status_q;
    count_d = count_q;
    if (pop) begin
      if (byte_cnt_q != 2'd0) begin
        byte_cnt_d = byte_cnt_q - 2'd1;
        bytes_d = {bytes_q[15:0], 8'd0};
      end else begin
        stat_pend_d = 1'b0;
      end
    end
    if (load_i) begin
      byte_cnt_d = bundle_i.n_bytes;
      stat_pend_d = bundle_i.has_status;
      bytes_d = bundle_i.bytes;
      status_d = bundle_i.status;
      count_d = bundle_i.byte_count;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_cnt_q <= 2'd0;
      stat_pend_q <= 1'b0;
    end else begin
      byte_cnt_q <= byte_cnt_d;
      stat_pend_q <= stat_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bytes_q <= bytes_d;
    status_q <= status_d;
    count_q <= count_d;
  end

endmodule

`default_nettype wire

[src/base64_chunk_decoder.sv]
// Top level of the streaming base64 chunk decoder.
`default_nettype none

// The decoder takes one base64 character per input beat and can accept one
// beat per cycle while the input is not stalled. An accepted character sits
// in an input register while the decode logic classifies it and updates the
// run state; a character that completes a group of four hands up to three
// decoded bytes, and the character marked last also hands a status, to a
// result buffer that sends them one output beat per cycle while the sink is
// ready. Characters that produce no result pass through without touching
// that buffer. A bundle holds the buffer until its last beat is taken, even
// with an always-ready sink, so the input stalls when the next character
// that produces results arrives before then. A full group that closes a
// chunk makes four beats, so an empty_chunk beat or a chunk shorter than
// four characters right behind it waits for them to drain. A sink that
// holds back beats stretches the drain and stalls the input the same way.
// The first result beat of a character is offered once the character has
// passed the input register and its bundle is loaded into the result buffer.
// Bytes stream out before the status, which is the beat with end_of_run set;
// the consumer must drop the bytes of a chunk whose status is not ok. An
// empty_chunk beat yields only the empty status and ends the chunk. The
// capacity register is written through the configuration port, which is
// always ready, and should only change while the decoder is idle.
module base64_chunk_decoder
  import b64d_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [CapW-1:0] cfg_data_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  in_item_t        in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output out_item_t       out_data_o
);

  logic [CapW-1:0] out_capacity_q;
  logic            in_valid_q;
  in_item_t        in_item_q;
  run_state_t      run_q, run_d;
  bundle_t         bundle;
  logic            has_results;
  logic            can_load;
  logic            advance;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_capacity_q <= CapReset;
    end else if (cfg_valid_i) begin
      out_capacity_q <= cfg_data_i;
    end
  end

  b64d_decode u_decode (
    .item_i         (in_item_q),
    .run_i          (run_q),
    .out_capacity_i (out_capacity_q),
    .run_o          (run_d),
    .bundle_o       (bundle)
  );

  // The held character moves on when it produces nothing or when the result
  // buffer can take its bundle this cycle.
  assign has_results = (bundle.n_bytes != 2'd0) || bundle.has_status;
  assign advance = in_valid_q && (!has_results || can_load);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      run_q <= '0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        run_q <= run_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_item_q <= in_data_i;
    end
  end

  b64d_serializer u_serializer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance && has_results),
    .bundle_i    (bundle),
    .can_load_o  (can_load),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // Only the status beat ends a chunk, and it carries no byte.
  a_eor_is_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_data_o.kind == KindStatus) == out_data_o.end_of_run))
    else $error("end_of_run does not match the beat kind");

  // Position in the group follows the character count until it saturates.
  a_pos_tracks_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (run_q.char_count < CharCntSat) |-> (run_q.pos == run_q.char_count[1:0]))
    else $error("group position out of step with character count");

  // A character that ends the chunk leaves a clean run state behind.
  a_run_cleared : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && bundle.has_status) |=>
      ((run_q.char_count == '0) && (run_q.pad == 2'd0) && !run_q.bad))
    else $error("run state not cleared at end of chunk");

endmodule

`default_nettype wire
